// File: rtl/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

  localparam int CAPACITY = 16;

  // Widths of the list bookkeeping.
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Fixed field widths.
  localparam int ACT_W = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int ST_W  = 2;
  localparam int IDX_W = 5;

  // Compare width for position against count, with headroom for count + 1.
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  // Common width for folding counts into the 5-bit result fields.
  localparam int XW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TRAVERSE = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] entry_value;
    logic [IDX_W-1:0]        entry_index;
    logic [IDX_W-1:0]        entry_count;
    logic                    final_result;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;      // capture the accepted transaction and set up the walk
    logic rd_en;      // read the entry under the walk pointer
    logic wr_shift;   // write back the previously read entry, one place over
    logic wr_put;     // write the new value at its slot
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;   // load the result register
    logic out_entry;  // result is a traverse entry rather than a status
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic go_ins;
    logic go_del;
    logic go_trav;
    logic rem_zero;   // no reads left in the walk
    logic rvalid;     // read data register holds an entry still to be used
  } sts_t;

endpackage

// File: rtl/positional_list_insert_delete.sv
`timescale 1ns / 1ps

// Positional list of up to pli_pkg::CAPACITY signed 32-bit words, positions
// counted from 1. Each input transaction inserts, deletes or traverses; insert
// and delete give one status result, traverse gives one result per entry with
// final_result marking the last (an empty list gives a single empty status).
// Bad positions and a full list are reported and leave the list untouched.
// One transaction is worked on at a time; in_ready is high only between
// transactions, while a finished result may still sit in the output register.
// The entry store has one write port and one registered read port and moves
// or reads one entry per cycle, a traverse only while the output does not
// stall. Insert walks from the tail down to its position, delete from its
// position up to the tail, and traverse over every entry.
// The store is not cleared at reset; only written entries are ever read.

module positional_list_insert_delete (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pli_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pli_pkg::out_t out_data
);

  pli_pkg::cmd_t cmd;
  pli_pkg::sts_t sts;

  // Sequence each transaction and own both handshakes.
  pli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the entry store, the count, the walk pointers and the result register.
  pli_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: rtl/pli_datapath.sv
`timescale 1ns / 1ps

module pli_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  pli_pkg::in_t    in_data,
  input  pli_pkg::cmd_t   cmd,
  output pli_pkg::sts_t   sts,
  output pli_pkg::out_t   out_data
);

  logic [pli_pkg::VAL_W-1:0] mem [pli_pkg::CAPACITY];

  logic [pli_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       rvalid_r;
  logic [pli_pkg::ACT_W-1:0]  act_r;
  logic [pli_pkg::VAL_W-1:0]  val_r;
  logic [pli_pkg::ADDR_W-1:0] put_addr_r;
  logic [pli_pkg::ST_W-1:0]   st_r;
  logic [pli_pkg::CNT_W-1:0]  ptr_r;
  logic [pli_pkg::CNT_W-1:0]  rem_r;
  logic [pli_pkg::VAL_W-1:0]  rdata_r;
  logic [pli_pkg::CNT_W-1:0]  raddr_r;
  pli_pkg::out_t              out_r;

  logic [pli_pkg::CMP_W-1:0]  pos_x, cnt_x;
  logic                       pos_zero, cnt_empty, cnt_full;
  logic [pli_pkg::ST_W-1:0]   st_calc;
  logic                       go_ins, go_del, go_trav;
  logic [pli_pkg::CNT_W-1:0]  rem_start, ptr_start;
  logic                       walk_down;
  logic [pli_pkg::ADDR_W-1:0] wr_addr;
  logic [pli_pkg::CNT_W-1:0]  entry_pos;
  logic [pli_pkg::XW-1:0]     idx_x, cnt_wx;

  // Classify the incoming transaction against the current count.
  always_comb begin
    pos_x     = pli_pkg::CMP_W'(in_data.position);
    cnt_x     = pli_pkg::CMP_W'(cnt_r);
    pos_zero  = (in_data.position == '0);
    cnt_empty = (cnt_r == '0);
    cnt_full  = (cnt_r == pli_pkg::CAP_CNT);
    st_calc   = pli_pkg::ST_DONE;
    go_ins    = 1'b0;
    go_del    = 1'b0;
    go_trav   = 1'b0;
    rem_start = cnt_r;
    ptr_start = '0;
    unique case (in_data.action)
      pli_pkg::ACT_INSERT: begin
        rem_start = pli_pkg::CNT_W'(cnt_x - pos_x + pli_pkg::CMP_W'(1));
        ptr_start = cnt_r - pli_pkg::CNT_W'(1);
        if (pos_zero || (pos_x > cnt_x + pli_pkg::CMP_W'(1))) begin
          st_calc = pli_pkg::ST_RANGE;
        end else if (cnt_full) begin
          st_calc = pli_pkg::ST_FULL;
        end else begin
          go_ins = 1'b1;
        end
      end
      pli_pkg::ACT_DELETE: begin
        rem_start = pli_pkg::CNT_W'(cnt_x - pos_x);
        ptr_start = pli_pkg::CNT_W'(pos_x);
        if (cnt_empty) begin
          st_calc = pli_pkg::ST_EMPTY;
        end else if (pos_zero || (pos_x > cnt_x)) begin
          st_calc = pli_pkg::ST_RANGE;
        end else begin
          go_del = 1'b1;
        end
      end
      pli_pkg::ACT_TRAVERSE: begin
        if (cnt_empty) begin
          st_calc = pli_pkg::ST_EMPTY;
        end else begin
          go_trav = 1'b1;
        end
      end
      default: begin
        st_calc = pli_pkg::ST_DONE;
      end
    endcase
  end

  // Insert walks from the tail downwards; delete and traverse walk upwards.
  assign walk_down = (act_r == pli_pkg::ACT_INSERT);
  assign wr_addr   = walk_down ? pli_pkg::ADDR_W'(raddr_r + pli_pkg::CNT_W'(1))
                               : pli_pkg::ADDR_W'(raddr_r - pli_pkg::CNT_W'(1));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + pli_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - pli_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rvalid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rvalid_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r      <= in_data.action;
      val_r      <= in_data.value;
      put_addr_r <= pli_pkg::ADDR_W'(in_data.position - pli_pkg::POS_W'(1));
      st_r       <= st_calc;
      ptr_r      <= ptr_start;
      rem_r      <= rem_start;
    end else if (cmd.rd_en) begin
      ptr_r <= walk_down ? ptr_r - pli_pkg::CNT_W'(1) : ptr_r + pli_pkg::CNT_W'(1);
      rem_r <= rem_r - pli_pkg::CNT_W'(1);
    end
  end

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      mem[wr_addr] <= rdata_r;
    end else if (cmd.wr_put) begin
      mem[put_addr_r] <= val_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[ptr_r[pli_pkg::ADDR_W-1:0]];
      raddr_r <= ptr_r;
    end
  end

  // Result register.
  always_comb begin
    entry_pos = raddr_r + pli_pkg::CNT_W'(1);
    idx_x     = pli_pkg::XW'(entry_pos);
    cnt_wx    = pli_pkg::XW'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.entry_count <= cnt_wx[pli_pkg::IDX_W-1:0];
      if (cmd.out_entry) begin
        out_r.status       <= pli_pkg::ST_DONE;
        out_r.entry_value  <= rdata_r;
        out_r.entry_index  <= idx_x[pli_pkg::IDX_W-1:0];
        out_r.final_result <= (rem_r == '0);
      end else begin
        out_r.status       <= st_r;
        out_r.entry_value  <= '0;
        out_r.entry_index  <= '0;
        out_r.final_result <= 1'b1;
      end
    end
  end

  assign out_data     = out_r;
  assign sts.go_ins   = go_ins;
  assign sts.go_del   = go_del;
  assign sts.go_trav  = go_trav;
  assign sts.rem_zero = (rem_r == '0);
  assign sts.rvalid   = rvalid_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pli_pkg::CAP_CNT)
    else $error("entry count above capacity");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_shift && cmd.wr_put))
    else $error("shift write and put write in one cycle");

  a_shift_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> rvalid_r)
    else $error("shift write without read data");

  a_inc_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |=> (cnt_r == $past(cnt_r) + pli_pkg::CNT_W'(1)))
    else $error("count did not advance on insert");

endmodule

// File: rtl/pli_ctrl.sv
`timescale 1ns / 1ps

module pli_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pli_pkg::sts_t sts,
  output pli_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS      = 6'b000010,
    S_DEL      = 6'b000100,
    S_TRAV_RD  = 6'b001000,
    S_TRAV_OUT = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          priority if (sts.go_ins) begin
            state_nxt = S_INS;
          end else if (sts.go_del) begin
            state_nxt = S_DEL;
          end else if (sts.go_trav) begin
            state_nxt = S_TRAV_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_INS: begin
        cmd.rd_en    = !sts.rem_zero;
        cmd.wr_shift = sts.rvalid;
        if (sts.rem_zero && !sts.rvalid) begin
          cmd.wr_put  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_DEL: begin
        cmd.rd_en    = !sts.rem_zero;
        cmd.wr_shift = sts.rvalid;
        if (sts.rem_zero && !sts.rvalid) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_TRAV_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_TRAV_OUT;
      end
      S_TRAV_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_entry = 1'b1;
          if (sts.rem_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

  a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && cmd.out_load) |=> (state_r == S_IDLE))
    else $error("status response not followed by idle");

endmodule

// File: sim/tb_positional_list_insert_delete.sv
`timescale 1ns / 1ps

module tb_positional_list_insert_delete;
  import pli_pkg::*;

  // Action code that the block treats as a no-op.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Settling time once the last expected result has been seen.
  localparam int TAIL_CYCLES = 40;
  localparam int RUN_LIMIT_NS = 10_000_000;

  // One row of the directed stimulus. A typed row carries its own expected
  // status and count; any other row is checked against the list model.
  typedef struct packed {
    in_t             item;
    logic [7:0]      reps;
    logic            typed;
    logic [ST_W-1:0] status;
    logic [7:0]      count;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Shadow copy of the list, advanced once per accepted transaction.
  logic signed [VAL_W-1:0] list_words [CAPACITY];
  int                      list_len;
  bit                      filling;

  out_t      step_results[$];   // results of the transaction just accepted
  out_t      awaited_results[$]; // results still to come out of the block
  stim_row_t stim_table[$];

  int mismatches;
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_request;

  positional_list_insert_delete DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #RUN_LIMIT_NS;
    $display("Mismatches found");
    $finish;
  end

  // Work out the results of one list operation and apply it to the shadow
  // list. Results land in step_results, in the order the block emits them.
  task automatic model_list_op(input in_t item);
    out_t r;
    int   pos;
    step_results.delete();
    pos = item.position;
    r = '0;
    r.status = ST_DONE;
    r.final_result = 1'b1;
    case (item.action)
      ACT_INSERT: begin
        // Range check wins over the full check.
        if (pos < 1 || pos > list_len + 1) begin
          r.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_len; k >= pos; k--) list_words[k] = list_words[k-1];
          list_words[pos-1] = item.value;
          list_len++;
        end
      end
      ACT_DELETE: begin
        // Empty list wins over the range check.
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < 1 || pos > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int k = pos; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      ACT_TRAVERSE: begin
        if (list_len == 0) r.status = ST_EMPTY;
      end
      default: ;
    endcase
    r.entry_count = IDX_W'(list_len);
    if (item.action == ACT_TRAVERSE && list_len > 0) begin
      // One result per entry, in list order; flag the last.
      for (int k = 0; k < list_len; k++) begin
        r.entry_value  = list_words[k];
        r.entry_index  = IDX_W'(k + 1);
        r.final_result = (k + 1 == list_len);
        step_results.push_back(r);
      end
    end else begin
      step_results.push_back(r);
    end
  endtask

  // Offer one transaction and hold it until the block takes it, idling
  // beforehand as the current sender setting asks. On acceptance, advance
  // the model and queue what the block must return: either the model's
  // results or, for a typed row, the single status result written in it.
  task automatic send_list_op(input in_t item, input bit typed,
                              input logic [ST_W-1:0] status, input int count);
    out_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    model_list_op(item);
    if (typed) begin
      r = '0;
      r.status       = status;
      r.entry_count  = IDX_W'(count);
      r.final_result = 1'b1;
      awaited_results.push_back(r);
    end else begin
      foreach (step_results[k]) awaited_results.push_back(step_results[k]);
    end
  endtask

  // Drop valid, wait for every awaited result, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic void add_row(input logic [ACT_W-1:0] action,
                                  input logic [VAL_W-1:0] value,
                                  input logic [POS_W-1:0] position,
                                  input int reps, input bit typed,
                                  input logic [ST_W-1:0] status,
                                  input int count);
    stim_row_t row;
    row.item.action   = action;
    row.item.value    = value;
    row.item.position = position;
    row.reps          = 8'(reps);
    row.typed         = typed;
    row.status        = status;
    row.count         = 8'(count);
    stim_table.push_back(row);
  endfunction

  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Random list operation. Most are well formed against the current list
  // length, swinging between filling and emptying so that both the full and
  // the empty list get visited; the rest are bad positions and no-ops.
  function automatic in_t pick_list_op();
    in_t item;
    int  roll;
    if (list_len == CAPACITY) filling = 1'b0;
    if (list_len == 0)        filling = 1'b1;
    roll = $urandom_range(99);
    item.value    = pick_word();
    item.position = POS_W'($urandom());
    if (roll < 10) begin
      item.action = ACT_TRAVERSE;
    end else if (roll < 15) begin
      item.action = ACT_UNUSED;
    end else if (roll < 22) begin
      // Bad position: zero or beyond the legal end.
      item.action = ($urandom_range(1) == 0) ? ACT_INSERT : ACT_DELETE;
      if ($urandom_range(2) == 0) begin
        item.position = '0;
      end else if (item.action == ACT_INSERT) begin
        item.position = POS_W'($urandom_range(63, list_len + 2));
      end else begin
        item.position = POS_W'($urandom_range(63, list_len + 1));
      end
    end else if ((roll < 80) == filling) begin
      item.action   = ACT_INSERT;
      item.position = POS_W'($urandom_range(list_len + 1, 1));
    end else begin
      item.action = ACT_DELETE;
      if (list_len > 0) item.position = POS_W'($urandom_range(list_len, 1));
    end
    return item;
  endfunction

  // Receiver: stall at the current rate, and on request hold off for a
  // counted stretch so the block backs up and stalls its input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every result transaction with the oldest awaited one.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d index %0d count %0d final %0d",
               out_data.status, out_data.entry_value, out_data.entry_index,
               out_data.entry_count, out_data.final_result);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, got %0d",
                 want.entry_value, out_data.entry_value);
          mismatches++;
        end
        if (out_data.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d",
                 want.entry_index, out_data.entry_index);
          mismatches++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 want.entry_count, out_data.entry_count);
          mismatches++;
        end
        if (out_data.final_result !== want.final_result) begin
          $error("final_result: expected %0d, got %0d",
                 want.final_result, out_data.final_result);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    in_t       item;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    mismatches      = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 0;
    list_len        = 0;
    filling         = 1'b1;
    foreach (list_words[k]) list_words[k] = '0;

    // Directed transactions. Typed rows hold the status and count at a glance;
    // the fill run and the traversals go through the model.
    add_row(ACT_TRAVERSE, 32'd0,        6'd0,  1,  1, ST_EMPTY, 0);  // empty walk
    add_row(ACT_DELETE,   32'd0,        6'd1,  1,  1, ST_EMPTY, 0);  // delete on empty
    add_row(ACT_INSERT,   32'd5,        6'd0,  1,  1, ST_RANGE, 0);  // position zero
    add_row(ACT_INSERT,   32'd6,        6'd2,  1,  1, ST_RANGE, 0);  // past count + 1
    add_row(ACT_INSERT,   32'h7FFF_FFFF, 6'd1, 1,  1, ST_DONE,  1);
    add_row(ACT_INSERT,   32'h8000_0000, 6'd1, 1,  1, ST_DONE,  2);  // at the head
    add_row(ACT_INSERT,   32'h1234_5678, 6'd2, 14, 0, ST_DONE,  0);  // fill the middle
    add_row(ACT_INSERT,   32'hFFFF_FFFF, 6'd17, 1, 1, ST_FULL,  16); // full list
    add_row(ACT_INSERT,   32'd3,        6'd18, 1,  1, ST_RANGE, 16); // range before full
    add_row(ACT_TRAVERSE, 32'd0,        6'd0,  1,  0, ST_DONE,  0);  // longest walk
    add_row(ACT_DELETE,   32'd0,        6'd0,  1,  1, ST_RANGE, 16);
    add_row(ACT_DELETE,   32'd0,        6'd16, 1,  1, ST_DONE,  15); // tail
    add_row(ACT_DELETE,   32'd0,        6'd1,  1,  1, ST_DONE,  14); // head
    add_row(ACT_UNUSED,   32'hFFFF_FFFF, 6'd63, 1, 1, ST_DONE,  14); // no-op code
    add_row(ACT_INSERT,   32'd0,        6'd15, 1,  1, ST_DONE,  15); // append
    add_row(ACT_TRAVERSE, 32'd0,        6'd0,  1,  0, ST_DONE,  0);

    // Hold reset, then release it once.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      for (int rep = 0; rep < row.reps; rep++) begin
        item = row.item;
        item.value = row.item.value + rep;
        send_list_op(item, row.typed, row.status, row.count);
      end
    end
    drain_results();

    // Random phases: no idling with a long receiver hold-off at the start,
    // then a sparse sender, a stalling receiver, and light idling on both.
    // Pause the sender between phases until every result has come back.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 250; end
        1: begin sender_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int n = 0; n < 85; n++) begin
        item = pick_list_op();
        send_list_op(item, 1'b0, ST_DONE, 0);
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
